// ===== design/ust_pkg.sv =====
package ust_pkg;

    // Message buffer sizing
    localparam int MESSAGE_DEPTH = 16;
    localparam int LEN_W         = $clog2(MESSAGE_DEPTH + 1);
    localparam int ADDR_W        = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;

    // Frame format
    localparam int DATA_BITS  = 8;
    localparam int BITPOS_W   = $clog2(DATA_BITS + 1);
    localparam int BITIDX_W   = $clog2(DATA_BITS);

    // Bit interval timer
    localparam int         PERIOD_W     = 8;
    localparam logic [7:0] PERIOD_RESET = 8'd104;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Encoding of the kind field on the input channel
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_rejected;
        logic finished;
    } out_item_t;

    // Classified request as it travels through the queue
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data_byte;
        logic       last_byte;
    } op_t;

endpackage

// ===== design/ust_front.sv =====
module ust_front
    import ust_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     op_valid,
    input  logic     op_ready,
    output op_t      op_data
);

    logic front_valid_reg;
    logic front_valid_next;
    op_t  op_reg;
    op_t  op_next;
    op_t  op_class;

    // Classify the incoming request; ticks carry no byte
    always_comb
    begin
        op_class.kind      = (in_data.kind == KIND_TICK) ? OP_TICK : OP_LOAD;
        op_class.data_byte = (in_data.kind == KIND_TICK) ? 8'd0 : in_data.data_byte;
        op_class.last_byte = (in_data.kind == KIND_TICK) ? 1'b0 : in_data.last_byte;
    end

    assign in_ready = !front_valid_reg || op_ready;

    // Hold the stage until the queue takes it
    always_comb
    begin
        front_valid_next = front_valid_reg;
        op_next          = op_reg;
        if (in_valid && in_ready)
        begin
            front_valid_next = 1'b1;
            op_next          = op_class;
        end
        else if (op_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign op_valid = front_valid_reg;
    assign op_data  = op_reg;

endmodule

// ===== design/ust_queue.sv =====
module ust_queue
    import ust_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_data
);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== design/ust_back.sv =====
module ust_back
    import ust_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  op_t                 op_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    input  logic [PERIOD_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_STOP
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic [LEN_W-1:0]      byte_pos_reg;
    logic [LEN_W-1:0]      byte_pos_next;
    logic [BITPOS_W-1:0]   bit_pos_reg;
    logic [BITPOS_W-1:0]   bit_pos_next;
    logic [PERIOD_W-1:0]   tick_reg;
    logic [PERIOD_W-1:0]   tick_next;
    logic [PERIOD_W-1:0]   period_reg;
    logic                  line_reg;
    logic                  line_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_reg;
    out_item_t             out_next;
    logic [7:0]            store_reg [MESSAGE_DEPTH];
    logic                  store_wr;
    logic [7:0]            cur_byte;
    logic                  take;
    logic                  rejected;
    logic                  done;

    // Take a request whenever the result slot is free or being drained
    assign op_ready = !out_valid_reg || out_ready;
    assign take     = op_valid && op_ready;
    assign cur_byte = store_reg[byte_pos_reg[ADDR_W-1:0]];

    // Apply one request to the frame state
    always_comb
    begin
        phase_next     = phase_reg;
        len_next       = len_reg;
        byte_pos_next  = byte_pos_reg;
        bit_pos_next   = bit_pos_reg;
        tick_next      = tick_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        store_wr       = 1'b0;
        rejected       = 1'b0;
        done           = 1'b0;
        if (take)
        begin
            if (op_data.kind == OP_LOAD)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    if (len_reg >= LEN_W'(MESSAGE_DEPTH))
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        store_wr = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    if (op_data.last_byte)
                    begin
                        phase_next    = PH_START;
                        byte_pos_next = '0;
                        bit_pos_next  = '0;
                        tick_next     = '0;
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (tick_reg == period_reg)
                begin
                    tick_next = '0;
                    case (phase_reg)
                        PH_START:
                        begin
                            line_next  = 1'b0;
                            phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (bit_pos_reg >= BITPOS_W'(DATA_BITS))
                            begin
                                byte_pos_next = byte_pos_reg + 1'b1;
                                bit_pos_next  = '0;
                                phase_next    = PH_STOP;
                                line_next     = 1'b1;
                            end
                            else
                            begin
                                line_next    = cur_byte[bit_pos_reg[BITIDX_W-1:0]];
                                bit_pos_next = bit_pos_reg + 1'b1;
                            end
                        end
                        PH_STOP:
                        begin
                            line_next = 1'b1;
                            if (byte_pos_reg >= len_reg)
                            begin
                                phase_next    = PH_IDLE;
                                len_next      = '0;
                                byte_pos_next = '0;
                                bit_pos_next  = '0;
                                done          = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_START;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            out_valid_next         = 1'b1;
            out_next.line_level    = line_next;
            out_next.busy_res      = (phase_next != PH_IDLE);
            out_next.load_rejected = rejected;
            out_next.finished      = done;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold frame state, the bit period and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            len_reg       <= '0;
            byte_pos_reg  <= '0;
            bit_pos_reg   <= '0;
            tick_reg      <= '0;
            line_reg      <= 1'b1;
            period_reg    <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            byte_pos_reg  <= byte_pos_next;
            bit_pos_reg   <= bit_pos_next;
            tick_reg      <= tick_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                period_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Append loaded bytes to the message buffer
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[len_reg[ADDR_W-1:0]] <= op_data.data_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (line_reg && tick_reg == '0 && byte_pos_reg == '0
                                    && bit_pos_reg == '0))
        else $error("idle with frame state not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= LEN_W'(MESSAGE_DEPTH)) && (byte_pos_reg <= len_reg))
        else $error("buffer length or byte position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (byte_pos_reg < len_reg
                                    && bit_pos_reg <= BITPOS_W'(DATA_BITS)))
        else $error("data phase past the message");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.finished) |-> (!out_reg.busy_res && out_reg.line_level))
        else $error("finished result while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped before it was taken");

endmodule

// ===== design/uart_serial_transmitter_unit.sv =====
// A request passes through the input stage, the two-entry request queue and the
// frame engine with its result register. Throughput: one request per cycle while out_ready
// is high; the frame engine applies one request each cycle unless the result slot stalls.
// Reset (rst_n, asynchronous, active low): idle, line high, empty message buffer,
// bit period 104; the message buffer contents are not cleared.
module uart_serial_transmitter_unit
    import ust_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data
);

    logic front_valid;
    logic front_ready;
    op_t  front_op;
    logic queue_valid;
    logic queue_ready;
    op_t  queue_op;

    // Period writes are always taken
    assign cfg_ready = 1'b1;

    ust_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op_data  (front_op)
    );

    ust_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_op)
    );

    ust_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_valid),
        .op_ready  (queue_ready),
        .op_data   (queue_op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule
